// ===== hw/rtl/svm_pkg.sv =====
// Shared constants and word types for the sample voice mixer.
`timescale 1ns / 1ps

package svm_pkg;

   // MEM_DEPTH must be a power of two so that addresses wrap by truncation.
   localparam int NUM_SLOTS = 32;
   localparam int MEM_DEPTH = 65536;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int SAMP_W = 16;
   localparam int LEN_W  = 17;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_QUEUE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_NONE = 2'd3;

   localparam logic signed [SAMP_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMP_W-1:0] SAMPLE_MIN = -16'sh8000;

   typedef struct packed {
      logic [1:0]               command;
      logic [15:0]              mem_address;
      logic signed [SAMP_W-1:0] sample_value;
      logic [15:0]              sound_start;
      logic [LEN_W-1:0]         sound_length;
   } svm_req_type;

   typedef struct packed {
      logic signed [SAMP_W-1:0] mixed_sample;
      logic                     sample_valid;
      logic [1:0]               queue_status;
      logic [4:0]               slot_index;
      logic [5:0]               active_voices;
   } svm_rsp_type;

   typedef struct packed {
      logic              load;
      logic              exec;
      logic              issue;
      logic [SLOT_W-1:0] slot;
   } svm_cmd_type;

   typedef struct packed {
      logic is_tick;
   } svm_stat_type;

endpackage

// ===== hw/rtl/svm_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/svm_ctrl.sv =====
// Controller state machine that sequences commands and the slot walk.
`timescale 1ns / 1ps

module svm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  svm_pkg::svm_stat_type stat,
   output svm_pkg::svm_cmd_type  cmd
);
   import svm_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_WALK  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            idx_in   = '0;
            state_in = stat.is_tick ? S_WALK : S_RESP;
         end
         S_WALK: begin
            cmd.issue = 1'b1;
            cmd.slot  = idx_ff;
            if (idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== hw/rtl/svm_dp.sv =====
// Datapath with the slot table, sample memory and saturating accumulator.
`timescale 1ns / 1ps

module svm_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  svm_pkg::svm_req_type  req_word,
   input  svm_pkg::svm_cmd_type  cmd,
   output svm_pkg::svm_stat_type stat,
   output svm_pkg::svm_rsp_type  rsp_word
);
   import svm_pkg::*;

   svm_req_type              req_ff, req_in;
   logic [NUM_SLOTS-1:0]     active_ff, active_in;
   logic [ADDR_W-1:0]        addr_ff [NUM_SLOTS];
   logic [ADDR_W-1:0]        addr_in [NUM_SLOTS];
   logic [LEN_W-1:0]         rem_ff [NUM_SLOTS];
   logic [LEN_W-1:0]         rem_in [NUM_SLOTS];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     acc_ff, acc_in;
   logic signed [SAMP_W-1:0] mixed_ff, mixed_in;
   logic [1:0]               status_ff, status_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     free_found;
   logic [SLOT_W-1:0]        free_idx;
   logic [SAMP_W-1:0]        rd_data;
   logic signed [SAMP_W:0]   sum;
   logic                     is_queue;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign is_queue = (req_ff.command == CMD_QUEUE);
   assign sum = {mixed_ff[SAMP_W-1], mixed_ff} + {rd_data[SAMP_W-1], rd_data};

   always_comb begin
      req_in    = cmd.load ? req_word : req_ff;
      active_in = active_ff;
      addr_in   = addr_ff;
      rem_in    = rem_ff;
      count_in  = count_ff;
      mixed_in  = mixed_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      acc_in    = cmd.issue && active_ff[cmd.slot];
      if (cmd.exec) begin
         mixed_in  = '0;
         status_in = ST_NONE;
         slot_in   = '0;
         if (is_queue) begin
            if (req_ff.sound_length == '0) begin
               status_in = ST_ZERO;
            end else if (!free_found) begin
               status_in = ST_FULL;
            end else begin
               status_in          = ST_OK;
               slot_in            = free_idx;
               active_in[free_idx] = 1'b1;
               addr_in[free_idx]   = ADDR_W'(req_ff.sound_start);
               rem_in[free_idx]    = req_ff.sound_length;
               count_in           = count_ff + CNT_W'(1);
            end
         end
      end
      if (cmd.issue && active_ff[cmd.slot]) begin
         addr_in[cmd.slot] = addr_ff[cmd.slot] + ADDR_W'(1);
         rem_in[cmd.slot]  = rem_ff[cmd.slot] - LEN_W'(1);
         if (rem_ff[cmd.slot] == LEN_W'(1)) begin
            active_in[cmd.slot] = 1'b0;
            count_in            = count_ff - CNT_W'(1);
         end
      end
      if (acc_ff) begin
         if (sum > 17'(SAMPLE_MAX)) begin
            mixed_in = SAMPLE_MAX;
         end else if (sum < 17'(SAMPLE_MIN)) begin
            mixed_in = SAMPLE_MIN;
         end else begin
            mixed_in = sum[SAMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= '0;
         acc_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      addr_ff   <= addr_in;
      rem_ff    <= rem_in;
      mixed_ff  <= mixed_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   svm_ram #(
      .WIDTH(SAMP_W),
      .DEPTH(MEM_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (cmd.exec && (req_ff.command == CMD_WRITE)),
      .wr_addr (ADDR_W'(req_ff.mem_address)),
      .wr_data (req_ff.sample_value),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff[cmd.slot]),
      .rd_data (rd_data)
   );

   assign stat.is_tick = (req_ff.command == CMD_TICK);

   assign rsp_word.mixed_sample  = mixed_ff;
   assign rsp_word.sample_valid  = (req_ff.command == CMD_TICK);
   assign rsp_word.queue_status  = status_ff;
   assign rsp_word.slot_index    = 5'(slot_ff);
   assign rsp_word.active_voices = 6'(count_ff);

endmodule

// ===== hw/rtl/sample_voice_mixer.sv =====
// Top level of the sample voice mixer: controller plus datapath.
// A write or queue word passes from accept through the execute and response states back
// to idle; its result strobes in the response state. A tick walks every slot and then
// drains before responding, with one sample memory read per slot per cycle in the walk.
// Synchronous reset frees all slots and clears the voice count; sample memory
// keeps its contents. The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps

module sample_voice_mixer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  svm_pkg::svm_req_type req_word,
   output logic                 rsp_valid,
   output svm_pkg::svm_rsp_type rsp_word
);
   import svm_pkg::*;

   svm_cmd_type  cmd;
   svm_stat_type stat;

   svm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   svm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_word (rsp_word)
   );

endmodule
